// ----- rtl/core/csa_pkg.sv -----
// Package for the contiguous segment allocator: codes, types and defaults.
`timescale 1ns / 1ps
`default_nettype none
package csa_pkg;
    localparam int          MAX_SEGMENTS_DEF = 16;
    localparam int          REPORT_LIMIT     = 16;
    localparam logic [31:0] TOTAL_MEM_RESET  = 32'd1048576;

    localparam logic [2:0] ACT_REQUEST = 3'd0;
    localparam logic [2:0] ACT_RELEASE = 3'd1;
    localparam logic [2:0] ACT_COMPACT = 3'd2;
    localparam logic [2:0] ACT_QUERY   = 3'd3;
    localparam logic [2:0] ACT_REPORT  = 3'd4;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NO_TASK  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_REQ_DO,
        S_SHIFT_UP,
        S_REQ_SPLIT,
        S_REL_NEXT,
        S_REL_PREV,
        S_SHIFT_DN,
        S_CMP_SCAN,
        S_CMP_TAIL,
        S_REPORT,
        S_RESULT
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/contiguous_segment_allocator_top.sv -----
// Top level of the contiguous segment allocator: table, sequencer and output register.
// A first-fit request stops its scan at the first hole that fits; a rejected or unknown
// word goes straight to its result. Report gives one entry per cycle while m_ready low
// does not hold the output.
// Throughput: one word in flight; s_ready is low until the result word is loaded, and
// a result held by m_ready low stalls the sequencer. Reset: synchronous active-low
// aresetn; the table becomes one hole of TOTAL_MEM_RESET.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_segment_allocator_top
    import csa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [31:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_action,
    input  wire  [7:0]  s_task_id,
    input  wire  [31:0] s_request_size,
    input  wire  [1:0]  s_fit_mode,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_seg_start,
    output logic [31:0] m_seg_end,
    output logic [7:0]  m_seg_owner,
    output logic        m_resident,
    output logic        m_last
);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic [31:0] start_mem [MAX_SEGMENTS];
    logic [31:0] size_mem  [MAX_SEGMENTS];
    logic [7:0]  owner_mem [MAX_SEGMENTS];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;      // scan index
    logic [CW-1:0] pick_reg, pick_next;
    logic          found_reg, found_next;
    logic [31:0]   psize_reg, psize_next;
    logic [2:0]    act_reg;
    logic [7:0]    task_reg;
    logic [31:0]   rsize_reg;
    logic [1:0]    mode_reg;
    logic [31:0]   addr_reg, addr_next;    // compact running address
    logic [31:0]   free_reg, free_next;
    logic [CW-1:0] n_reg, n_next;          // compact write index / first entry to remove
    logic [1:0]    drop_reg, drop_next;    // entries removed by a release

    // result word being built
    logic [1:0]  r_status;
    logic [31:0] r_start, r_end;
    logic [7:0]  r_owner;
    logic        r_res, r_last, r_load;

    // table write port
    logic          w_en;
    logic [IW-1:0] w_idx;
    logic [31:0]   w_start, w_size;
    logic [7:0]    w_owner;

    logic [IW-1:0] ix;
    logic [IW-1:0] ixm1;
    logic [IW-1:0] ixp1;
    logic [CW-1:0] idx_dn;
    logic [IW-1:0] ixd;
    logic [31:0]   c_start, c_size;
    logic [7:0]    c_owner;
    logic          prev_hole;

    assign ix   = idx_reg[IW-1:0];
    assign ixm1 = ix - 1'b1;
    assign ixp1 = ix + 1'b1;
    assign idx_dn = idx_reg + CW'(drop_reg);
    assign ixd  = idx_dn[IW-1:0];
    assign c_start = start_mem[ix];
    assign c_size  = size_mem[ix];
    assign c_owner = owner_mem[ix];
    assign prev_hole = (idx_reg != '0) && (owner_mem[ixm1] == 8'd0);

    logic in_acc, out_busy;
    assign out_busy = m_valid && !m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;

    logic [CW-1:0] rep_n;
    assign rep_n = (int'(count_reg) < REPORT_LIMIT) ? count_reg : CW'(REPORT_LIMIT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (s_action)
                        ACT_REQUEST: begin
                            if (s_task_id == 8'd0 || s_request_size == 32'd0
                                || s_fit_mode > FIT_WORST)
                                state_next = S_RESULT;
                            else
                                state_next = S_SCAN;
                        end
                        ACT_RELEASE: state_next = (s_task_id == 8'd0) ? S_RESULT : S_SCAN;
                        ACT_QUERY:   state_next = (s_task_id == 8'd0) ? S_RESULT : S_SCAN;
                        ACT_COMPACT: state_next = S_CMP_SCAN;
                        ACT_REPORT:  state_next = S_REPORT;
                        default:     state_next = S_RESULT;
                    endcase
                end
            end
            S_SCAN: begin
                if (idx_reg >= count_reg) begin
                    if (act_reg == ACT_REQUEST)
                        state_next = found_reg ? S_REQ_DO : S_RESULT;
                    else
                        state_next = S_RESULT;
                end else if (act_reg == ACT_REQUEST) begin
                    if (c_owner == 8'd0 && c_size >= rsize_reg && !found_reg
                        && mode_reg == FIT_FIRST)
                        state_next = S_REQ_DO;
                end else if (c_owner == task_reg) begin
                    state_next = (act_reg == ACT_RELEASE) ? S_REL_NEXT : S_RESULT;
                end
            end
            S_REQ_DO: begin
                if (psize_reg == rsize_reg)
                    state_next = S_RESULT;
                else if (count_reg >= CW'(MAX_SEGMENTS))
                    state_next = S_RESULT;
                else
                    state_next = S_SHIFT_UP;
            end
            S_SHIFT_UP: if (idx_reg <= pick_reg + 1'b1) state_next = S_REQ_SPLIT;
            S_REQ_SPLIT: state_next = S_RESULT;
            S_REL_NEXT: state_next = S_REL_PREV;
            S_REL_PREV: state_next = (n_reg != '0 || prev_hole) ? S_SHIFT_DN : S_RESULT;
            S_SHIFT_DN: if (idx_dn >= count_reg) state_next = S_RESULT;
            S_CMP_SCAN: if (idx_reg >= count_reg) state_next = S_CMP_TAIL;
            S_CMP_TAIL: state_next = S_RESULT;
            S_REPORT: begin
                if (!out_busy && idx_reg + 1'b1 >= rep_n) state_next = S_RESULT;
            end
            S_RESULT: if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        pick_next  = pick_reg;
        found_next = found_reg;
        psize_next = psize_reg;
        addr_next  = addr_reg;
        free_next  = free_reg;
        n_next     = n_reg;
        drop_next  = drop_reg;
        w_en = 1'b0; w_idx = ix; w_start = c_start; w_size = c_size; w_owner = c_owner;
        r_load = 1'b0; r_status = ST_OK; r_start = '0; r_end = '0; r_owner = '0;
        r_res = 1'b0; r_last = 1'b1;
        case (state_reg)
            S_IDLE: begin
                idx_next = '0; found_next = 1'b0; addr_next = '0; free_next = '0;
                n_next = '0; drop_next = '0;
            end
            S_SCAN: begin
                if (idx_reg < count_reg) begin
                    if (act_reg == ACT_REQUEST) begin
                        if (c_owner == 8'd0 && c_size >= rsize_reg) begin
                            if (!found_reg || (mode_reg == FIT_BEST && c_size < psize_reg)
                                || (mode_reg == FIT_WORST && c_size > psize_reg)) begin
                                found_next = 1'b1; pick_next = idx_reg; psize_next = c_size;
                            end
                        end
                    end else if (c_owner == task_reg) begin
                        found_next = 1'b1; pick_next = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                if (state_next == S_REQ_DO) begin
                    idx_next = pick_next;
                end else if (state_next == S_REL_NEXT) begin
                    w_en = 1'b1; w_owner = 8'd0;
                    idx_next = idx_reg;
                end
            end
            S_REQ_DO: begin
                if (psize_reg == rsize_reg) begin
                    w_en = 1'b1; w_owner = task_reg;
                end
                idx_next = count_reg;
            end
            S_SHIFT_UP: begin
                // entry idx takes entry idx-1
                if (idx_reg > pick_reg + 1'b1) begin
                    w_en = 1'b1; w_start = start_mem[ixm1]; w_size = size_mem[ixm1];
                    w_owner = owner_mem[ixm1];
                    idx_next = idx_reg - 1'b1;
                end else begin
                    w_en = 1'b1; w_start = start_mem[ixm1] + rsize_reg;
                    w_size = psize_reg - rsize_reg; w_owner = 8'd0;
                    idx_next = pick_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            S_REQ_SPLIT: begin
                w_en = 1'b1; w_size = rsize_reg; w_owner = task_reg;
            end
            S_REL_NEXT: begin
                // merge following hole into entry idx, then drop that hole
                n_next = '0;
                if (idx_reg + 1'b1 < count_reg && owner_mem[ixp1] == 8'd0) begin
                    w_en = 1'b1; w_size = c_size + size_mem[ixp1];
                    n_next = idx_reg + 1'b1;
                    drop_next = 2'd1;
                end
            end
            S_REL_PREV: begin
                idx_next = n_reg;
                // fold entry idx into the hole before it; removal then starts at idx
                if (prev_hole) begin
                    w_en = 1'b1; w_idx = ixm1; w_start = start_mem[ixm1];
                    w_size = size_mem[ixm1] + c_size; w_owner = 8'd0;
                    idx_next = idx_reg;
                    n_next = idx_reg;
                    drop_next = drop_reg + 2'd1;
                end
            end
            S_SHIFT_DN: begin
                if (idx_dn < count_reg) begin
                    w_en = 1'b1; w_start = start_mem[ixd]; w_size = size_mem[ixd];
                    w_owner = owner_mem[ixd];
                    idx_next = idx_reg + 1'b1;
                end else begin
                    count_next = count_reg - CW'(drop_reg);
                end
            end
            S_CMP_SCAN: begin
                if (idx_reg < count_reg) begin
                    if (c_owner == 8'd0) begin
                        free_next = free_reg + c_size;
                    end else begin
                        w_en = 1'b1; w_idx = n_reg[IW-1:0]; w_start = addr_reg;
                        addr_next = addr_reg + c_size;
                        n_next = n_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CMP_TAIL: begin
                if (free_reg != '0 || n_reg == '0) begin
                    w_en = 1'b1; w_idx = n_reg[IW-1:0]; w_start = addr_reg;
                    w_size = free_reg; w_owner = 8'd0;
                    count_next = n_reg + 1'b1;
                end else begin
                    count_next = n_reg;
                end
            end
            S_REPORT: begin
                if (!out_busy) begin
                    r_load = 1'b1; r_start = c_start; r_end = c_start + c_size;
                    r_owner = c_owner; r_last = (idx_reg + 1'b1 >= rep_n);
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RESULT: begin
                if (!out_busy && act_reg != ACT_REPORT) begin
                    r_load = 1'b1;
                    case (act_reg)
                        ACT_REQUEST: begin
                            if (task_reg == 8'd0) r_status = ST_NO_TASK;
                            else if (rsize_reg == '0 || mode_reg > FIT_WORST || !found_reg)
                                r_status = ST_NO_FIT;
                            else if (psize_reg != rsize_reg && !n_reg[0])
                                r_status = ST_FULL;
                            else begin
                                r_start = start_mem[pick_reg[IW-1:0]];
                                r_end = r_start + rsize_reg; r_owner = task_reg;
                            end
                        end
                        ACT_RELEASE: if (!found_reg) r_status = ST_NO_TASK;
                        ACT_QUERY: r_res = found_reg;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        // mark a successful split or exact fit so RESULT can tell it from table full
        if (state_reg == S_REQ_SPLIT) n_next = {{(CW-1){1'b0}}, 1'b1};
        if (state_reg == S_REQ_DO && psize_reg == rsize_reg) n_next = {{(CW-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mem[0] <= '0;
            size_mem[0]  <= TOTAL_MEM_RESET;
            owner_mem[0] <= 8'd0;
        end else if (cfg_we) begin
            start_mem[0] <= '0;
            size_mem[0]  <= cfg_wdata;
            owner_mem[0] <= 8'd0;
        end else if (w_en) begin
            start_mem[w_idx] <= w_start;
            size_mem[w_idx]  <= w_size;
            owner_mem[w_idx] <= w_owner;
        end
        if (in_acc) begin
            act_reg <= s_action; task_reg <= s_task_id;
            rsize_reg <= s_request_size; mode_reg <= s_fit_mode;
        end
        pick_reg <= pick_next; psize_reg <= psize_next; addr_reg <= addr_next;
        free_reg <= free_next; n_reg <= n_next; idx_reg <= idx_next;
        found_reg <= found_next; drop_reg <= drop_next;
        if (r_load) begin
            m_status <= r_status; m_seg_start <= r_start; m_seg_end <= r_end;
            m_seg_owner <= r_owner; m_resident <= r_res; m_last <= r_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= cfg_we ? CW'(1) : count_next;
            if (r_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/contiguous_segment_allocator_top_tb.sv -----
// Self-checking testbench for the contiguous segment allocator top level.
`timescale 1ns / 1ps
module contiguous_segment_allocator_top_tb;
    import csa_pkg::*;

    localparam int          SEGS        = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  ACT_BAD5    = 3'd5;
    localparam logic [2:0]  ACT_BAD6    = 3'd6;
    localparam logic [2:0]  ACT_BAD7    = 3'd7;
    localparam logic [1:0]  FIT_BAD     = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  task_id;
        logic [31:0] req_size;
        logic [1:0]  fit;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] seg_start;
        logic [31:0] seg_end;
        logic [7:0]  owner;
        logic        resident;
        logic        last;
    } seg_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [7:0]  s_task_id = '0;
    logic [31:0] s_request_size = '0;
    logic [1:0]  s_fit_mode = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_seg_start;
    logic [31:0] m_seg_end;
    logic [7:0]  m_seg_owner;
    logic        m_resident;
    logic        m_last;

    contiguous_segment_allocator_top u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_task_id(s_task_id), .s_request_size(s_request_size),
        .s_fit_mode(s_fit_mode), .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_seg_start(m_seg_start), .m_seg_end(m_seg_end),
        .m_seg_owner(m_seg_owner), .m_resident(m_resident), .m_last(m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow segment table
    logic [31:0] mem_total;
    logic [31:0] tbl_start [SEGS];
    logic [31:0] tbl_size  [SEGS];
    logic [7:0]  tbl_owner [SEGS];
    int          tbl_count;

    cmd_t        pending_cmds [$];
    seg_word_t   expected_words [$];
    cmd_t        held_cmd;
    int          send_idle = 27;
    int          recv_idle = 51;
    int          n_accepted = 0;
    int          n_words = 0;
    int          n_mismatch = 0;
    int          n_cycles = 0;
    int          n_full = 0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    function automatic seg_word_t mk_word(logic [1:0] st, logic [31:0] a, logic [31:0] b,
                                          logic [7:0] own, logic res, logic lst);
        seg_word_t w;
        w.status = st; w.seg_start = a; w.seg_end = b;
        w.owner = own; w.resident = res; w.last = lst;
        return w;
    endfunction

    function automatic void table_reset(logic [31:0] total);
        mem_total = total;
        for (int k = 0; k < SEGS; k++) begin
            tbl_start[k] = '0; tbl_size[k] = '0; tbl_owner[k] = '0;
        end
        tbl_size[0] = total;
        tbl_count = 1;
    endfunction

    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k]  = tbl_size[k+1];
            tbl_owner[k] = tbl_owner[k+1];
        end
        tbl_count--;
    endfunction

    function automatic int owner_index(logic [7:0] t);
        if (t == 0) return -1;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_owner[i] == t) return i;
        return -1;
    endfunction

    function automatic void alloc_segment(cmd_t c);
        int pick;
        pick = -1;
        if (c.task_id == 0) begin
            expected_words.push_back(mk_word(ST_NO_TASK, 0, 0, 0, 0, 1)); return;
        end
        if (c.req_size == 0 || c.fit == FIT_BAD) begin
            expected_words.push_back(mk_word(ST_NO_FIT, 0, 0, 0, 0, 1)); return;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_owner[i] != 0 || tbl_size[i] < c.req_size) continue;
            if (pick < 0) begin
                pick = i;
                if (c.fit == FIT_FIRST) break;
            end else if (c.fit == FIT_BEST && tbl_size[i] < tbl_size[pick]) begin
                pick = i;
            end else if (c.fit == FIT_WORST && tbl_size[i] > tbl_size[pick]) begin
                pick = i;
            end
        end
        if (pick < 0) begin
            expected_words.push_back(mk_word(ST_NO_FIT, 0, 0, 0, 0, 1)); return;
        end
        if (tbl_size[pick] != c.req_size) begin
            if (tbl_count >= SEGS) begin
                n_full++;
                expected_words.push_back(mk_word(ST_FULL, 0, 0, 0, 0, 1)); return;
            end
            for (int k = tbl_count; k > pick + 1; k--) begin
                tbl_start[k] = tbl_start[k-1];
                tbl_size[k]  = tbl_size[k-1];
                tbl_owner[k] = tbl_owner[k-1];
            end
            tbl_start[pick+1] = tbl_start[pick] + c.req_size;
            tbl_size[pick+1]  = tbl_size[pick] - c.req_size;
            tbl_owner[pick+1] = 0;
            tbl_count++;
            tbl_size[pick] = c.req_size;
        end
        tbl_owner[pick] = c.task_id;
        expected_words.push_back(mk_word(ST_OK, tbl_start[pick],
                                         tbl_start[pick] + c.req_size, c.task_id, 0, 1));
    endfunction

    function automatic void free_segment(logic [7:0] t);
        int i;
        i = owner_index(t);
        if (i < 0) begin
            expected_words.push_back(mk_word(ST_NO_TASK, 0, 0, 0, 0, 1)); return;
        end
        tbl_owner[i] = 0;
        if (i + 1 < tbl_count && tbl_owner[i+1] == 0) begin
            tbl_size[i] = tbl_size[i] + tbl_size[i+1];
            drop_entry(i + 1);
        end
        if (i > 0 && tbl_owner[i-1] == 0) begin
            tbl_size[i-1] = tbl_size[i-1] + tbl_size[i];
            drop_entry(i);
        end
        expected_words.push_back(mk_word(ST_OK, 0, 0, 0, 0, 1));
    endfunction

    function automatic void compact_table();
        int          n;
        logic [31:0] addr, free_sum;
        n = 0; addr = 0; free_sum = 0;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_owner[i] == 0) begin
                free_sum = free_sum + tbl_size[i];
            end else begin
                tbl_start[n] = addr;
                tbl_size[n]  = tbl_size[i];
                tbl_owner[n] = tbl_owner[i];
                addr = addr + tbl_size[i];
                n++;
            end
        end
        if (free_sum != 0 || n == 0) begin
            tbl_start[n] = addr; tbl_size[n] = free_sum; tbl_owner[n] = 0;
            n++;
        end
        tbl_count = n;
        expected_words.push_back(mk_word(ST_OK, 0, 0, 0, 0, 1));
    endfunction

    function automatic void predict_words(cmd_t c);
        int n;
        case (c.action)
            ACT_REQUEST: alloc_segment(c);
            ACT_RELEASE: free_segment(c.task_id);
            ACT_COMPACT: compact_table();
            ACT_QUERY: begin
                expected_words.push_back(mk_word(ST_OK, 0, 0, 0,
                                                 owner_index(c.task_id) >= 0, 1));
            end
            ACT_REPORT: begin
                n = tbl_count < REPORT_LIMIT ? tbl_count : REPORT_LIMIT;
                for (int i = 0; i < n; i++)
                    expected_words.push_back(mk_word(ST_OK, tbl_start[i],
                        tbl_start[i] + tbl_size[i], tbl_owner[i], 0, i + 1 == n));
            end
            default: expected_words.push_back(mk_word(ST_OK, 0, 0, 0, 0, 1));
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_words(held_cmd);
                n_accepted <= n_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
                    held_cmd = pending_cmds.pop_front();
                    s_valid        <= 1'b1;
                    s_action       <= held_cmd.action;
                    s_task_id      <= held_cmd.task_id;
                    s_request_size <= held_cmd.req_size;
                    s_fit_mode     <= held_cmd.fit;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off to back up the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted == 40) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        seg_word_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = mk_word(m_status, m_seg_start, m_seg_end, m_seg_owner, m_resident, m_last);
            n_words <= n_words + 1;
            if (expected_words.size() == 0) begin
                n_mismatch = n_mismatch + 1;
                if (n_mismatch <= 10)
                    $display("unexpected word: st=%0d start=%h end=%h own=%0d res=%0d last=%0d",
                             got.status, got.seg_start, got.seg_end, got.owner,
                             got.resident, got.last);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display({"word mismatch: exp st=%0d start=%h end=%h own=%0d res=%0d ",
                                  "last=%0d / got st=%0d start=%h end=%h own=%0d res=%0d ",
                                  "last=%0d"},
                                 want.status, want.seg_start, want.seg_end, want.owner,
                                 want.resident, want.last, got.status, got.seg_start,
                                 got.seg_end, got.owner, got.resident, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic cmd_t mk_cmd(logic [2:0] a, logic [7:0] t, logic [31:0] sz,
                                    logic [1:0] f);
        cmd_t c;
        c.action = a; c.task_id = t; c.req_size = sz; c.fit = f;
        return c;
    endfunction

    function automatic void push_random(int n, logic [31:0] total);
        cmd_t        c;
        int          r;
        logic [31:0] span;
        span = (total >> 3) + 1;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            c = mk_cmd(ACT_REQUEST, 8'($urandom_range(12, 1)), 32'd0,
                       2'($urandom_range(2)));
            if (r < 45) begin
                case ($urandom_range(3))
                    0: c.req_size = $urandom_range(8, 1);
                    1: c.req_size = $urandom;
                    default: c.req_size = $urandom_range(span, 1);
                endcase
            end else if (r < 70) begin
                c.action = ACT_RELEASE;
            end else if (r < 78) begin
                c.action = ACT_QUERY;
            end else if (r < 84) begin
                c.action = ACT_COMPACT;
            end else if (r < 90) begin
                c.action = ACT_REPORT;
            end else begin
                // noise: odd actions, odd tasks, odd fit codes, zero sizes
                c.action   = 3'($urandom_range(7));
                c.task_id  = 8'($urandom_range(255));
                c.req_size = ($urandom_range(1) != 0) ? 32'd0 : $urandom;
                c.fit      = 2'($urandom_range(3));
            end
            pending_cmds.push_back(c);
        end
    endfunction

    task automatic drain();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_total(logic [31:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        table_reset(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        table_reset(TOTAL_MEM_RESET);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: error codes, fit modes, merges, odd actions, report
        pending_cmds.push_back(mk_cmd(ACT_QUERY,   5, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 0, 10, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_QUERY,   0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 1, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 1, 16, FIT_BAD));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 1, 32'hFFFF_FFFF, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 1, 100, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 2, 200, FIT_BEST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 3, 300, FIT_WORST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 1, 50, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 2, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 1, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_QUERY,   1, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 3, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REPORT,  0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 1, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 9, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_BAD5, 255, 32'hFFFF_FFFF, FIT_BAD));
        pending_cmds.push_back(mk_cmd(ACT_BAD6, 1, 1, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_BAD7, 0, 0, FIT_WORST));
        pending_cmds.push_back(mk_cmd(ACT_COMPACT, 0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REPORT, 0, 0, FIT_FIRST));
        push_random(40, mem_total);
        drain();

        // one-byte memory: exact fit, compaction with no free space left
        set_total(32'd1);
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 7, 1, FIT_BEST));
        pending_cmds.push_back(mk_cmd(ACT_COMPACT, 0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REPORT, 0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 8, 1, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 7, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REQUEST, 8, 2, FIT_WORST));
        push_random(15, mem_total);
        drain();

        send_idle = 51;
        recv_idle = 27;
        // full-range memory: fill the table until it overflows
        set_total(32'hFFFF_FFFF);
        for (int i = 1; i <= 16; i++)
            pending_cmds.push_back(mk_cmd(ACT_REQUEST, 8'(i), 1, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REPORT, 0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_RELEASE, 4, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_COMPACT, 0, 0, FIT_FIRST));
        pending_cmds.push_back(mk_cmd(ACT_REPORT, 0, 0, FIT_FIRST));
        push_random(30, mem_total);
        drain();

        set_total($urandom_range(4000, 64));
        push_random(30, mem_total);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_total(32'd4096);
        push_random(20, mem_total);
        drain();

        $display("ran %0d items through five memory sizes, %0d result words checked,",
                 n_accepted, n_words);
        $display("table overflow seen %0d times, one long output stall", n_full);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad words", n_mismatch);
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/csa_pkg.sv
rtl/core/contiguous_segment_allocator_top.sv
tb/sv/contiguous_segment_allocator_top_tb.sv
